/* rtl/sobel_edge_magnitude_rgb_assert.svh */
// Assertion macros shared by the checker of the Sobel edge block.
// Depends on nothing; the user supplies clock and reset names.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// Checked only while reset is released.
`define SEM_ASSERT(name, clock, rst_n, prop) \
	name: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error("sem assertion failed");

// Checked at every clock edge, reset included.
`define SEM_ASSERT_ALL(name, clock, prop) \
	name: assert property (@(posedge clock) prop) \
		else $error("sem assertion failed");

`endif

/* rtl/sem_pkg.sv */
// Package of the Sobel edge magnitude block: fixed widths, register codes,
// and the command and status structs between controller and datapath.
package sem_pkg;

	localparam int CH_BITS = 8;
	localparam int PIX_BITS = 3 * CH_BITS;
	localparam int NUM_CH = 3;
	localparam int CFG_BITS = 16;
	localparam int HEIGHT_BITS = 16;
	localparam int GRAD_BITS = 11;
	localparam int SQ_BITS = 22;
	localparam int ROOT_IN_BITS = 16;
	localparam int ROOT_STEPS = 8;
	localparam logic [SQ_BITS-1:0] SQ_LIMIT = 22'd65280;
	localparam logic [CH_BITS-1:0] CH_MAX = 8'hff;
	localparam logic [HEIGHT_BITS-1:0] ROW_MAX = 16'hffff;

	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic load;
		logic shift;
		logic grad;
		logic square;
		logic root_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic flush_idle;
		logic due;
		logic root_done;
		logic out_free;
	} status_t;

endpackage

/* rtl/sem_ctrl.sv */
// Controller of the Sobel edge block: sequences one transaction through
// line-store read, window shift and, if a result is due, gradient, square, root
// and output load. Depends on sem_pkg.
module sem_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sem_pkg::status_t status,
	output sem_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SHIFT = 7'b0000010,
		ST_GRAD  = 7'b0000100,
		ST_SQR   = 7'b0001000,
		ST_START = 7'b0010000,
		ST_ROOT  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !status.flush_idle) begin
					cmd.load = 1'b1;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d = status.due ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d = ST_SQR;
			end
			ST_SQR: begin
				cmd.square = 1'b1;
				state_d = ST_START;
			end
			ST_START: begin
				cmd.root_start = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (status.root_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/sem_root.sv */
// Bit-pair integer square root of a 16-bit value, one step per cycle.
// Gives the floor root and the remainder. Depends on sem_pkg.
module sem_root (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [sem_pkg::ROOT_IN_BITS-1:0]    value,
	output logic [sem_pkg::CH_BITS-1:0]         root,
	output logic [sem_pkg::CH_BITS:0]           rem,
	output logic                                done
);

	logic [sem_pkg::ROOT_IN_BITS:0] v_q;
	logic [sem_pkg::ROOT_IN_BITS:0] res_q;
	logic [sem_pkg::ROOT_IN_BITS:0] bit_q;
	logic [2:0]                     cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [sem_pkg::ROOT_IN_BITS:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'(sem_pkg::ROOT_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= {1'b0, value};
			res_q <= '0;
			bit_q <= 17'h4000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[sem_pkg::CH_BITS-1:0];
	assign rem = v_q[sem_pkg::CH_BITS:0];
	assign done = done_q;

endmodule

/* rtl/sem_datapath.sv */
// Datapath of the Sobel edge block: configuration registers, two row stores,
// the 3x3 window, position counters, gradients, squares, root lanes and
// the output register. Depends on sem_pkg and sem_root.
module sem_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_index,
	input  logic [sem_pkg::CFG_BITS-1:0]      cfg_wr_data,
	input  logic                              opcode,
	input  logic [sem_pkg::CH_BITS-1:0]       in_red,
	input  logic [sem_pkg::CH_BITS-1:0]       in_green,
	input  logic [sem_pkg::CH_BITS-1:0]       in_blue,
	input  logic                              in_valid,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sem_pkg::CH_BITS-1:0]       out_red,
	output logic [sem_pkg::CH_BITS-1:0]       out_green,
	output logic [sem_pkg::CH_BITS-1:0]       out_blue,
	output logic                              frame_last,
	input  sem_pkg::cmd_t                     cmd,
	output sem_pkg::status_t                  status
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = WW + sem_pkg::HEIGHT_BITS;

	logic [10:0]                        frame_width_q;
	logic [sem_pkg::HEIGHT_BITS-1:0]    frame_height_q;
	logic [WW-1:0]                      w_c;
	logic [sem_pkg::HEIGHT_BITS-1:0]    h_c;
	logic [PW-1:0]                      wh_q;

	logic [sem_pkg::PIX_BITS-1:0]       upper_mem [MAX_WIDTH];
	logic [sem_pkg::PIX_BITS-1:0]       lower_mem [MAX_WIDTH];
	logic [sem_pkg::PIX_BITS-1:0]       top_q, mid_q, px_q;
	logic [sem_pkg::PIX_BITS-1:0]       win_q [3][3];

	logic [CW-1:0]                      in_col_q;
	logic [sem_pkg::HEIGHT_BITS-1:0]    in_row_q;
	logic [PW-1:0]                      out_pos_q;
	logic [CW-1:0]                      ocol_q;
	logic [sem_pkg::HEIGHT_BITS-1:0]    orow_q;

	logic signed [sem_pkg::GRAD_BITS-1:0] gx_q [sem_pkg::NUM_CH];
	logic signed [sem_pkg::GRAD_BITS-1:0] gy_q [sem_pkg::NUM_CH];
	logic signed [sem_pkg::GRAD_BITS-1:0] gx_c [sem_pkg::NUM_CH];
	logic signed [sem_pkg::GRAD_BITS-1:0] gy_c [sem_pkg::NUM_CH];
	logic [sem_pkg::SQ_BITS-1:0]          sq_q [sem_pkg::NUM_CH];
	logic [sem_pkg::NUM_CH-1:0]           big_q;
	logic [sem_pkg::CH_BITS-1:0]          root_w [sem_pkg::NUM_CH];
	logic [sem_pkg::CH_BITS:0]            rem_w [sem_pkg::NUM_CH];
	logic [sem_pkg::NUM_CH-1:0]           done_w;
	logic [sem_pkg::CH_BITS-1:0]          mag_c [sem_pkg::NUM_CH];

	logic                                 out_valid_q;
	logic [sem_pkg::CH_BITS-1:0]          out_ch_q [sem_pkg::NUM_CH];
	logic                                 frame_last_q;
	logic                                 last_c;

	always_comb begin
		if (frame_width_q < 11'd2) begin
			w_c = WW'(2);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(frame_width_q);
		end
		h_c = (frame_height_q < 16'd2) ? 16'd2 : frame_height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 11'd640;
			frame_height_q <= 16'd480;
		end else if (cfg_wr_en) begin
			if (cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
				frame_width_q <= cfg_wr_data[10:0];
			end else begin
				frame_height_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		wh_q <= PW'(w_c) * PW'(h_c);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			top_q <= upper_mem[in_col_q];
			mid_q <= lower_mem[in_col_q];
			px_q <= (opcode == sem_pkg::OP_FLUSH) ? '0 : {in_blue, in_green, in_red};
		end
		if (cmd.shift) begin
			upper_mem[in_col_q] <= mid_q;
			lower_mem[in_col_q] <= px_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_q;
			win_q[1][2] <= mid_q;
			win_q[2][2] <= px_q;
		end
	end

	assign last_c = (32'(out_pos_q) + 32'd1) >= 32'(wh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_pos_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cmd.shift) begin
			if ((32'(in_col_q) + 32'd1) >= 32'(w_c)) begin
				in_col_q <= '0;
				if (in_row_q < sem_pkg::ROW_MAX) begin
					in_row_q <= in_row_q + 16'd1;
				end
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
		end else if (cmd.load_out) begin
			if (last_c) begin
				in_col_q <= '0;
				in_row_q <= '0;
				out_pos_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				out_pos_q <= out_pos_q + PW'(1);
				if ((32'(ocol_q) + 32'd1) >= 32'(w_c)) begin
					ocol_q <= '0;
					orow_q <= orow_q + 16'd1;
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
		end
	end

	always_comb begin
		logic [sem_pkg::CH_BITS-1:0] p [3][3];
		logic                        off;
		logic [9:0]                  a, b;
		for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					off = (i == 0 && orow_q == '0)
						|| (i == 2 && (32'(orow_q) + 32'd1) >= 32'(h_c))
						|| (j == 0 && ocol_q == '0)
						|| (j == 2 && (32'(ocol_q) + 32'd1) == 32'(w_c));
					p[i][j] = off ? '0 : win_q[i][j][ch*sem_pkg::CH_BITS +: sem_pkg::CH_BITS];
				end
			end
			a = 10'(p[0][2]) + {1'b0, p[1][2], 1'b0} + 10'(p[2][2]);
			b = 10'(p[0][0]) + {1'b0, p[1][0], 1'b0} + 10'(p[2][0]);
			gx_c[ch] = $signed({1'b0, a}) - $signed({1'b0, b});
			a = 10'(p[2][0]) + {1'b0, p[2][1], 1'b0} + 10'(p[2][2]);
			b = 10'(p[0][0]) + {1'b0, p[0][1], 1'b0} + 10'(p[0][2]);
			gy_c[ch] = $signed({1'b0, a}) - $signed({1'b0, b});
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
			if (cmd.grad) begin
				gx_q[ch] <= gx_c[ch];
				gy_q[ch] <= gy_c[ch];
			end
			if (cmd.square) begin
				sq_q[ch] <= $unsigned(sem_pkg::SQ_BITS'(gx_q[ch]) * sem_pkg::SQ_BITS'(gx_q[ch]))
					+ $unsigned(sem_pkg::SQ_BITS'(gy_q[ch]) * sem_pkg::SQ_BITS'(gy_q[ch]));
			end
			if (cmd.root_start) begin
				big_q[ch] <= sq_q[ch] > sem_pkg::SQ_LIMIT;
			end
		end
	end

	for (genvar g = 0; g < sem_pkg::NUM_CH; g++) begin : g_root
		sem_root u_root (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (cmd.root_start),
			.value  (sq_q[g][sem_pkg::ROOT_IN_BITS-1:0]),
			.root   (root_w[g]),
			.rem    (rem_w[g]),
			.done   (done_w[g])
		);
	end

	always_comb begin
		for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
			if (big_q[ch]) begin
				mag_c[ch] = sem_pkg::CH_MAX;
			end else if (rem_w[ch] > {1'b0, root_w[ch]}) begin
				mag_c[ch] = root_w[ch] + 8'd1;
			end else begin
				mag_c[ch] = root_w[ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
				out_ch_q[ch] <= mag_c[ch];
			end
			frame_last_q <= last_c;
		end
	end

	assign status.flush_idle = in_valid && (opcode == sem_pkg::OP_FLUSH)
		&& in_row_q == '0 && in_col_q == '0;
	assign status.due = in_row_q >= 16'd2 || (in_row_q == 16'd1 && in_col_q != '0);
	assign status.root_done = &done_w;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_red = out_ch_q[0];
	assign out_green = out_ch_q[1];
	assign out_blue = out_ch_q[2];
	assign frame_last = frame_last_q;

endmodule

/* rtl/sobel_edge_magnitude_rgb.sv */
// Top level of the streaming 3x3 Sobel edge magnitude block on RGB pixels.
// Joins the controller and the datapath. Depends on sem_pkg, sem_ctrl,
// sem_datapath.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    opcode, in_red, in_green, in_blue
//   output    out_valid / out_ready  out_red, out_green, out_blue, frame_last
//   config    cfg_wr_en              cfg_index, cfg_wr_data
//
// A transaction that yields a result runs from acceptance through row-store
// read, window shift, gradient and square stages and the eight steps of the
// square-root lanes to output load; no new one is accepted before then. One
// without a result returns to idle after the window shift. A flush at the
// start of a frame is dropped in the cycle it is accepted.
// The output register holds a result under stall; the block waits to load it.
// Reset clears control state, configuration and the window; row stores are not cleared.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_index,
	input  logic [sem_pkg::CFG_BITS-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [sem_pkg::CH_BITS-1:0]  in_red,
	input  logic [sem_pkg::CH_BITS-1:0]  in_green,
	input  logic [sem_pkg::CH_BITS-1:0]  in_blue,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sem_pkg::CH_BITS-1:0]  out_red,
	output logic [sem_pkg::CH_BITS-1:0]  out_green,
	output logic [sem_pkg::CH_BITS-1:0]  out_blue,
	output logic                         frame_last
);

	sem_pkg::cmd_t    cmd;
	sem_pkg::status_t status;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sem_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.opcode      (opcode),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.in_valid    (in_valid),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.frame_last  (frame_last),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

/* rtl/sem_checker.sv */
// Port checker of the Sobel edge block and its bind to the top level.
// Depends on sobel_edge_magnitude_rgb_assert.svh.
`include "sobel_edge_magnitude_rgb_assert.svh"

module sem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic       frame_last
);

	// A stalled result keeps its payload.
	`SEM_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(frame_last))
	// A new result is loaded only while no transaction can be accepted.
	`SEM_ASSERT(a_load_busy, clk, arst_n, $rose(out_valid) |-> !$past(in_ready))
	// Reset leaves no result pending.
	`SEM_ASSERT_ALL(a_reset_empty, clk, !arst_n |=> !out_valid)

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_red    (out_red),
	.out_green  (out_green),
	.out_blue   (out_blue),
	.frame_last (frame_last)
);
